@@ design/trm_pkg.sv @@
`default_nettype none

package trm_pkg;

    localparam int COORD_W = 16;
    localparam int COUNT_W = 4;
    localparam int MASK_W  = 10;
    localparam int CFG_IDX_W = 3;

    // Largest number of point items taken from one frame.
    localparam logic [COUNT_W-1:0] MAX_TOUCH_POINTS = 4'd10;

    typedef logic [COORD_W-1:0]   t_coord;
    typedef logic [COUNT_W-1:0]   t_count;
    typedef logic [MASK_W-1:0]    t_mask;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_SCREEN_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_SCREEN_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_PANEL_ID      = 3'd2;
    localparam t_cfg_idx CFG_LANDSCAPE     = 3'd3;
    localparam t_cfg_idx CFG_MAX_POINTS    = 3'd4;

    localparam t_coord RST_SCREEN_WIDTH  = 16'd800;
    localparam t_coord RST_SCREEN_HEIGHT = 16'd480;
    localparam t_coord RST_PANEL_ID      = 16'd0;
    localparam t_count RST_MAX_POINTS    = 4'd5;

    localparam logic [7:0] STATUS_READY_BIT = 8'h80;
    localparam logic [7:0] STATUS_COUNT_MSK = 8'h0F;

    localparam logic REQ_STATUS = 1'b0;
    localparam logic REQ_POINT  = 1'b1;

    localparam t_coord PANEL_A = 16'h5510;
    localparam t_coord PANEL_B = 16'h5310;
    localparam t_coord PANEL_C = 16'h7796;
    localparam t_coord PANEL_D = 16'h7789;
    localparam t_coord PANEL_E = 16'h9806;

    typedef struct packed {
        logic   point_valid;
        t_coord map_x;
        t_coord map_y;
        t_count slot;
        logic   frame_done;
        t_count touch_count;
        logic   pressed;
        t_mask  touch_mask;
        logic   clear_status;
        logic   press_edge;
    } t_result;

    // Panels whose preferred orientation is the opposite of the default one.
    function automatic logic is_inverted_panel(input t_coord id);
        is_inverted_panel = (id == PANEL_A) || (id == PANEL_B) || (id == PANEL_C) ||
                            (id == PANEL_D) || (id == PANEL_E);
    endfunction

endpackage

`default_nettype wire

@@ design/trm_if.sv @@
`default_nettype none

interface trm_req_if import trm_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   req_type;
    logic   [7:0] status_byte;
    t_coord raw_x;
    t_coord raw_y;
    logic   read_failed;

    modport source (output valid, req_type, status_byte, raw_x, raw_y, read_failed,
                    input ready);
    modport sink   (input valid, req_type, status_byte, raw_x, raw_y, read_failed,
                    output ready);
endinterface

interface trm_res_if import trm_pkg::*; ();
    logic   valid;
    logic   ready;
    logic   point_valid;
    t_coord map_x;
    t_coord map_y;
    t_count slot;
    logic   frame_done;
    t_count touch_count;
    logic   pressed;
    t_mask  touch_mask;
    logic   clear_status;
    logic   press_edge;

    modport source (output valid, point_valid, map_x, map_y, slot, frame_done,
                    touch_count, pressed, touch_mask, clear_status, press_edge,
                    input ready);
    modport sink   (input valid, point_valid, map_x, map_y, slot, frame_done,
                    touch_count, pressed, touch_mask, clear_status, press_edge,
                    output ready);
endinterface

interface trm_cfg_if import trm_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cfg_idx index;
    t_coord   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ design/touch_report_mapper_core.sv @@
// Channel    Direction  Port     Carries
// request    in         i_req    req_type, status_byte, raw_x, raw_y, read_failed
// result     out        o_res    one result per request, mapped point and frame summary
// config     in         i_cfg    register index and write data, always ready
//
// Each request is decoded, mapped and registered into the result register in the
// cycle it is accepted, and its result appears in the next cycle. One request per
// cycle is taken while the result register is empty or is being drained in the same
// cycle. Reset (synchronous, active low) closes any frame, clears the press history
// and restores the register defaults.
`default_nettype none

module touch_report_mapper_core import trm_pkg::*; #(
    parameter t_count MAX_TOUCH_PTS = MAX_TOUCH_POINTS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    trm_req_if.sink     i_req,
    trm_res_if.source   o_res,
    trm_cfg_if.sink     i_cfg
);

    // Configuration registers
    t_coord r_width, r_height, r_panel_id;
    logic   r_landscape;
    t_count r_max_points;

    // Frame state
    logic   r_frame_open, n_frame_open;
    t_count r_points_left, n_points_left;
    t_count r_valid_cnt, n_valid_cnt;
    t_mask  r_slot_mask, n_slot_mask;
    logic   r_last_pressed, n_last_pressed;

    // Result register
    logic    r_out_valid;
    t_result r_res, n_res;

    logic accept;
    logic ready_bit;
    t_count status_cnt;
    logic use_rot, rot_in, id_in, map_ok;
    t_coord map_x, map_y;
    t_count left_dec, cnt_inc;
    t_mask slot_onehot;
    t_mask mask_upd;
    logic pr;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign accept      = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= RST_SCREEN_WIDTH;
            r_height     <= RST_SCREEN_HEIGHT;
            r_panel_id   <= RST_PANEL_ID;
            r_landscape  <= 1'b0;
            r_max_points <= RST_MAX_POINTS;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_SCREEN_WIDTH:  r_width      <= i_cfg.data;
                CFG_SCREEN_HEIGHT: r_height     <= i_cfg.data;
                CFG_PANEL_ID:      r_panel_id   <= i_cfg.data;
                CFG_LANDSCAPE:     r_landscape  <= i_cfg.data[0];
                CFG_MAX_POINTS:    r_max_points <= i_cfg.data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // The rotated candidate is inside exactly when raw_y < W and raw_x < H, the
    // identity one when raw_x < W and raw_y < H. The preferred candidate is used when it
    // is inside, else the other one if it is inside, else the point maps to zero.
    always_comb begin
        use_rot = is_inverted_panel(r_panel_id) ? r_landscape : !r_landscape;
        rot_in  = (i_req.raw_y < r_width) && (i_req.raw_x < r_height);
        id_in   = (i_req.raw_x < r_width) && (i_req.raw_y < r_height);
        map_ok  = rot_in || id_in;
        if (rot_in && (use_rot || !id_in)) begin
            map_x = r_width - 16'd1 - i_req.raw_y;
            map_y = i_req.raw_x;
        end else if (id_in) begin
            map_x = i_req.raw_x;
            map_y = i_req.raw_y;
        end else begin
            map_x = '0;
            map_y = '0;
        end
    end

    always_comb begin
        n_frame_open   = r_frame_open;
        n_points_left  = r_points_left;
        n_valid_cnt    = r_valid_cnt;
        n_slot_mask    = r_slot_mask;
        n_last_pressed = r_last_pressed;
        n_res          = '0;

        ready_bit   = (i_req.status_byte & STATUS_READY_BIT) != 8'h00;
        status_cnt  = i_req.status_byte[COUNT_W-1:0] & STATUS_COUNT_MSK[COUNT_W-1:0];
        left_dec    = (r_points_left != '0) ? r_points_left - 4'd1 : '0;
        cnt_inc     = r_valid_cnt + 4'd1;
        slot_onehot = t_mask'(1'b1) << r_valid_cnt;
        mask_upd    = r_slot_mask | slot_onehot;
        pr          = 1'b0;

        if (i_req.req_type == REQ_STATUS) begin
            // A status always closes whatever frame was open.
            n_frame_open = 1'b0;
            if (!i_req.read_failed) begin
                n_res.clear_status = ready_bit && (status_cnt <= r_max_points);
                if (!ready_bit || status_cnt == '0 || status_cnt > r_max_points) begin
                    n_res.frame_done = 1'b1;
                end else begin
                    n_frame_open  = 1'b1;
                    n_points_left = (status_cnt < MAX_TOUCH_PTS) ? status_cnt
                                                                : MAX_TOUCH_PTS;
                    n_valid_cnt   = '0;
                    n_slot_mask   = '0;
                end
            end
        end else if (r_frame_open) begin
            if (!i_req.read_failed && map_ok) begin
                n_res.point_valid = 1'b1;
                n_res.map_x       = map_x;
                n_res.map_y       = map_y;
                n_res.slot        = r_valid_cnt;
                n_slot_mask       = mask_upd;
                n_valid_cnt       = cnt_inc;
            end
            n_points_left = left_dec;
            if (left_dec == '0) begin
                pr                 = n_valid_cnt != '0;
                n_res.frame_done   = 1'b1;
                n_res.touch_count  = n_valid_cnt;
                n_res.pressed      = pr;
                n_res.touch_mask   = pr ? n_slot_mask : '0;
                n_res.press_edge   = pr && !r_last_pressed;
                n_last_pressed     = pr;
                n_frame_open       = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open   <= 1'b0;
            r_points_left  <= '0;
            r_valid_cnt    <= '0;
            r_slot_mask    <= '0;
            r_last_pressed <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_frame_open   <= n_frame_open;
                r_points_left  <= n_points_left;
                r_valid_cnt    <= n_valid_cnt;
                r_slot_mask    <= n_slot_mask;
                r_last_pressed <= n_last_pressed;
                r_out_valid    <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.point_valid  = r_res.point_valid;
    assign o_res.map_x        = r_res.map_x;
    assign o_res.map_y        = r_res.map_y;
    assign o_res.slot         = r_res.slot;
    assign o_res.frame_done   = r_res.frame_done;
    assign o_res.touch_count  = r_res.touch_count;
    assign o_res.pressed      = r_res.pressed;
    assign o_res.touch_mask   = r_res.touch_mask;
    assign o_res.clear_status = r_res.clear_status;
    assign o_res.press_edge   = r_res.press_edge;

endmodule

`default_nettype wire

@@ design/trm_checker.sv @@
`default_nettype none

module trm_checker import trm_pkg::*; (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         i_req_valid,
    input wire         i_req_ready,
    input wire         i_res_valid,
    input wire         i_res_ready,
    input wire         i_point_valid,
    input wire         i_frame_done,
    input wire t_count i_touch_count,
    input wire         i_pressed,
    input wire t_mask  i_touch_mask,
    input wire         i_clear_status,
    input wire         i_press_edge
);

    // A stalled result stays on the port.
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // Every accepted request produces a result in the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> i_res_valid)
        else $error("accepted request gave no result");

    // A finished frame is pressed exactly when it holds touches, and then slot 0 is set.
    a_pressed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_frame_done |->
            (i_pressed == (i_touch_count != '0)) && (i_pressed == i_touch_mask[0]))
        else $error("frame summary inconsistent");

    // A press edge only comes with a pressed frame end.
    a_edge_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_press_edge |-> i_pressed && i_frame_done)
        else $error("press edge without a pressed frame");

    // A mapped point never carries a status write-back request.
    a_point_no_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_point_valid |-> !i_clear_status)
        else $error("point result with clear request");

endmodule

bind touch_report_mapper_core trm_checker u_trm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_valid    (i_req.valid),
    .i_req_ready    (i_req.ready),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_point_valid  (o_res.point_valid),
    .i_frame_done   (o_res.frame_done),
    .i_touch_count  (o_res.touch_count),
    .i_pressed      (o_res.pressed),
    .i_touch_mask   (o_res.touch_mask),
    .i_clear_status (o_res.clear_status),
    .i_press_edge   (o_res.press_edge)
);

`default_nettype wire
